[src/ghash_pkg.sv]
package ghash_pkg;

  localparam int unsigned BLOCK_BITS = 128;
  localparam int unsigned WORD_BITS  = 64;
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned BLOCK_BYTES = BLOCK_BITS / BYTE_BITS;
  localparam int unsigned POS_BITS   = $clog2(BLOCK_BYTES);
  localparam int unsigned CNT_BITS   = $clog2(BLOCK_BITS);

  // Reduction constant for x^128 + x^7 + x^2 + x + 1 in reflected order.
  localparam logic [BYTE_BITS-1:0] REDUCE_TOP = 8'hE1;

  typedef logic [BLOCK_BITS-1:0] block_t;
  typedef logic [WORD_BITS-1:0]  word_t;

  typedef enum logic [1:0] {
    OP_ABSORB   = 2'd0,
    OP_FINALIZE = 2'd1,
    OP_RESTART  = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH = 2'd0,
    CFG_KEY_LOW  = 2'd1,
    CFG_NONE_2   = 2'd2,
    CFG_NONE_3   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT_HI,
    ST_EMIT_LO
  } state_t;

endpackage

[src/ghash_mul.sv]
module ghash_mul import ghash_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  input  block_t a,
  input  block_t h,
  output logic   done,
  output block_t product
);

  block_t x;
  block_t z;
  block_t v;
  logic [CNT_BITS-1:0] cnt;
  logic busy;

  block_t z_next;
  block_t v_next;

  // One bit of a per cycle, most significant first.
  always_comb begin
    z_next = x[BLOCK_BITS-1] ? (z ^ v) : z;
    v_next = v >> 1;
    if (v[0]) begin
      v_next[BLOCK_BITS-1 -: BYTE_BITS] = v_next[BLOCK_BITS-1 -: BYTE_BITS] ^ REDUCE_TOP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(BLOCK_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= a;
      z <= '0;
      v <= h;
    end else if (busy) begin
      x <= x << 1;
      z <= z_next;
      v <= v_next;
    end
  end

  assign product = z;

endmodule

[src/ghash_gf128_authenticator.sv]
// GHASH authenticator over GF(2^128), as used by GCM.
// Input stream (s_axis_*): tuser carries the op code, tdata[7:0] the message
// byte. Op absorb XORs the byte into the accumulator Y at the running byte
// position; op finalize emits the token; op restart clears Y and the
// position; op code 3 is dropped without effect.
// Output stream (m_axis_*): two transactions per finalize, tdata carrying a
// 64-bit big-endian half of Y, high half first, tlast on the low half.
// Configuration (cfg_*): index 0 writes key bytes 0..7, index 1 bytes 8..15;
// cfg_ready is always high. Write the key only while the block is idle.
// Sequence: the sixteenth byte of a block starts a bit-serial multiply by H
// that walks one bit of Y per cycle. A finalize with a partial block adds
// the same multiply, then loads the two halves into the output register,
// one per cycle as the receiver takes them.
// Reset clears Y, the position, the key and any pending output; the block
// is ready for input on the first cycle after reset.
// A stalled receiver holds the high half in the output register; the low
// half waits until it is taken. Once the low half is loaded the input side
// reopens, so absorbing continues while the last word still waits.
module ghash_gf128_authenticator import ghash_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] token_word
  output logic        m_axis_tlast,   // last_word
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  state_t state;
  state_t state_next;

  block_t y;
  block_t y_absorb;
  block_t key;
  logic [POS_BITS-1:0] pos;
  logic finalize_pending;

  logic in_fire;
  op_t  op;
  logic out_free;
  logic mul_start;
  logic mul_done;
  block_t mul_product;

  logic load_hi;
  logic load_lo;

  assign op        = op_t'(s_axis_tuser);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  // XOR the byte into Y; byte position 0 is the most significant byte.
  always_comb begin
    y_absorb = y;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      if (pos == POS_BITS'(BLOCK_BYTES - 1 - i)) begin
        y_absorb[i*BYTE_BITS +: BYTE_BITS] = y[i*BYTE_BITS +: BYTE_BITS] ^ s_axis_tdata;
      end
    end
  end

  // Multiply on the last byte of a block, or on finalize of a partial block.
  always_comb begin
    mul_start = 1'b0;
    if (in_fire) begin
      case (op)
        OP_ABSORB:   mul_start = (pos == POS_BITS'(BLOCK_BYTES - 1));
        OP_FINALIZE: mul_start = (pos != '0);
        default:     mul_start = 1'b0;
      endcase
    end
  end

  ghash_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       ((in_fire && op == OP_ABSORB) ? y_absorb : y),
    .h       (key),
    .done    (mul_done),
    .product (mul_product)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && op == OP_FINALIZE) begin
          state_next = mul_start ? ST_MUL : ST_EMIT_HI;
        end else if (mul_start) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          state_next = finalize_pending ? ST_EMIT_HI : ST_IDLE;
        end
      end
      ST_EMIT_HI: begin
        if (out_free) begin
          state_next = ST_EMIT_LO;
        end
      end
      ST_EMIT_LO: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    s_axis_tready = 1'b0;
    load_hi       = 1'b0;
    load_lo       = 1'b0;
    case (state)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_MUL:     s_axis_tready = 1'b0;
      ST_EMIT_HI: load_hi = out_free;
      ST_EMIT_LO: load_lo = out_free;
      default:    s_axis_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      y                <= '0;
      pos              <= '0;
      key              <= '0;
      finalize_pending <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_KEY_HIGH: key[BLOCK_BITS-1 -: WORD_BITS] <= cfg_data;
          CFG_KEY_LOW:  key[WORD_BITS-1:0]             <= cfg_data;
          default:      ;
        endcase
      end

      if (in_fire) begin
        case (op)
          OP_ABSORB: begin
            y   <= y_absorb;
            pos <= pos + 1'b1;
          end
          OP_FINALIZE: begin
            finalize_pending <= 1'b1;
            pos              <= '0;
          end
          OP_RESTART: begin
            y   <= '0;
            pos <= '0;
          end
          default: ;
        endcase
      end

      if (mul_done) begin
        y <= mul_product;
      end

      if (load_lo) begin
        finalize_pending <= 1'b0;
      end

      if (load_hi || load_lo) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output payload: no reset needed
  always_ff @(posedge clk) begin
    if (load_hi) begin
      m_axis_tdata <= y[BLOCK_BITS-1 -: WORD_BITS];
      m_axis_tlast <= 1'b0;
    end else if (load_lo) begin
      m_axis_tdata <= y[WORD_BITS-1:0];
      m_axis_tlast <= 1'b1;
    end
  end

endmodule

[src/ghash_checker.sv]
module ghash_checker import ghash_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Reset leaves the input open and the output empty.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (s_axis_tready && !m_axis_tvalid))
    else $error("ghash: bad state after reset");

  // A stalled token word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("ghash: output changed while stalled");

  // The high half is always followed directly by the low half.
  a_hi_then_lo: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tlast))
    else $error("ghash: low half missing after high half");

  // A finalize closes the input: tready is low right after it is taken.
  a_finalize_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_FINALIZE) |=> !s_axis_tready)
    else $error("ghash: input accepted right after finalize");

endmodule

bind ghash_gf128_authenticator ghash_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/ghash_gf128_authenticator_tb.sv]
module ghash_gf128_authenticator_tb;
  import ghash_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Run limit in clock cycles. The slowest correct run is roughly 1400 items
  // times (a full multiply + a long sender gap) plus the output stalls, well
  // under this limit.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // Cycles to let pass before a key write. An absorb that completes a block
  // keeps the block busy for the multiply without giving any result.
  localparam int unsigned SETTLE_CYCLES = 2 * BLOCK_BITS;
  localparam int unsigned PHASE_ITEMS   = 330;

  // One token half as it leaves the block.
  typedef struct packed {
    word_t word;
    logic  is_last;
  } token_half_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;  // [7:0] data_byte
  logic [1:0]  s_axis_tuser = '0;  // [1:0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;       // [63:0] token_word
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Shadow of the block: hash key, running accumulator Y and byte position.
  block_t                ghash_key;
  block_t                ghash_acc;
  logic [POS_BITS-1:0]   ghash_pos;

  token_half_t           pending_token_q[$];

  // Idle percentages of the current phase.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned items_seen    = 0;
  int unsigned halves_seen   = 0;
  int unsigned mult_count    = 0;
  int unsigned key_writes    = 0;

  ghash_gf128_authenticator u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Receiver: stall at random with the phase's percentage.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Y * H in GF(2^128): walk Y from its top bit, shift V right each step and
  // fold the dropped bit back in with the reflected reduction byte.
  function automatic block_t gf128_mult(block_t y, block_t h);
    block_t z;
    block_t v;
    logic   carry;
    z = '0;
    v = h;
    for (int k = 0; k < BLOCK_BITS; k++) begin
      if (y[BLOCK_BITS-1-k]) begin
        z ^= v;
      end
      carry = v[0];
      v = v >> 1;
      if (carry) begin
        v[BLOCK_BITS-1 -: BYTE_BITS] ^= REDUCE_TOP;
      end
    end
    return z;
  endfunction

  // Advance the shadow state by one accepted transaction and queue the token
  // halves it produces.
  function automatic void predict_ghash_item(op_t op, logic [7:0] data_byte);
    token_half_t half;
    case (op)
      OP_ABSORB: begin
        // byte 0 is the most significant byte of Y
        ghash_acc[BLOCK_BITS-1-BYTE_BITS*ghash_pos -: BYTE_BITS] ^= data_byte;
        if (ghash_pos == POS_BITS'(BLOCK_BYTES - 1)) begin
          ghash_acc = gf128_mult(ghash_acc, ghash_key);
          mult_count++;
        end
        ghash_pos = ghash_pos + 1'b1;
      end
      OP_FINALIZE: begin
        // a partial block is padded with zeroes: multiply Y as it stands
        if (ghash_pos != '0) begin
          ghash_acc = gf128_mult(ghash_acc, ghash_key);
          ghash_pos = '0;
          mult_count++;
        end
        half.word    = ghash_acc[BLOCK_BITS-1 -: WORD_BITS];
        half.is_last = 1'b0;
        pending_token_q.push_back(half);
        half.word    = ghash_acc[WORD_BITS-1:0];
        half.is_last = 1'b1;
        pending_token_q.push_back(half);
      end
      OP_RESTART: begin
        ghash_acc = '0;
        ghash_pos = '0;
      end
      default: ;  // unused op code: drop
    endcase
  endfunction

  // Scoreboard: track key writes and input transactions, and compare each
  // output transaction with the oldest expected token half.
  always @(posedge clk) begin : scoreboard
    token_half_t want;
    if (rst) begin
      ghash_key = '0;
      ghash_acc = '0;
      ghash_pos = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        halves_seen++;
        if (pending_token_q.size() == 0) begin
          $error("unexpected token half: token_word=%h last_word=%b",
                 m_axis_tdata, m_axis_tlast);
          error_count++;
        end else begin
          want = pending_token_q.pop_front();
          if (m_axis_tdata !== want.word) begin
            $error("token_word mismatch: expected %h, actual %h", want.word, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tlast !== want.is_last) begin
            $error("last_word mismatch: expected %b, actual %b", want.is_last, m_axis_tlast);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index_t'(cfg_index))
          CFG_KEY_HIGH: ghash_key[BLOCK_BITS-1 -: WORD_BITS] = cfg_data;
          CFG_KEY_LOW:  ghash_key[WORD_BITS-1:0] = cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        items_seen++;
        predict_ghash_item(op_t'(s_axis_tuser), s_axis_tdata);
      end
    end
  end

  // Send one input transaction after a random idle gap. Hold valid high
  // across back-to-back transactions; drop it only when a gap follows.
  task automatic send_item(op_t op, logic [7:0] data_byte);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < 60) begin
      gap++;
    end
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= data_byte;
    do @(posedge clk); while (!s_axis_tready);
    if (op != OP_UNUSED) begin
      items_sent++;
    end
  endtask

  // Drop valid, let the scoreboard take the last transaction, wait for every
  // expected token half, then let a full multiply run out so the block is idle.
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_token_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_index_t index, logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    key_writes++;
  endtask

  task automatic load_key(logic [63:0] key_high, logic [63:0] key_low);
    settle_block();
    write_cfg(CFG_KEY_HIGH, key_high);
    write_cfg(CFG_KEY_LOW, key_low);
  endtask

  // Directed: empty token, byte extremes, ignored op code, padding, repeated
  // finalize, absorbing after finalize, restart and one full block.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_key(64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
    send_item(OP_FINALIZE, 8'hFF);       // token of an empty message
    send_item(OP_ABSORB, 8'hFF);
    send_item(OP_ABSORB, 8'h00);
    send_item(OP_UNUSED, 8'hFF);         // must leave Y and position alone
    send_item(OP_FINALIZE, 8'h00);       // pads the two-byte block
    send_item(OP_FINALIZE, 8'hA5);       // no bytes between: same token
    send_item(OP_ABSORB, 8'h80);         // continues from the emitted Y
    send_item(OP_RESTART, 8'hFF);
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      send_item(OP_ABSORB, 8'(8'h11 * i + 8'h01));
    end
    send_item(OP_FINALIZE, 8'h5A);       // block already multiplied
  endtask

  // Writes to the unused register indexes must not touch the key.
  task automatic test_unused_cfg_index();
    settle_block();
    write_cfg(CFG_NONE_2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(CFG_NONE_3, {$urandom, $urandom});
    send_item(OP_RESTART, 8'h00);
    for (int i = 0; i < 21; i++) begin
      send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
    end
    send_item(OP_FINALIZE, 8'h00);
  endtask

  // Random messages: mostly restart, random bytes and a finalize, with some
  // noise transactions in between. The key write does not clear Y, so the
  // first session of a phase may continue from the previous one.
  task automatic test_random_sessions(int unsigned send_pct, int unsigned recv_pct,
                                      logic [63:0] key_high, logic [63:0] key_low);
    int unsigned first_item;
    int unsigned msg_len;
    load_key(key_high, key_low);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    first_item = items_sent;
    while (items_sent - first_item < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 75) begin
        if ($urandom_range(0, 3) != 0) begin
          send_item(OP_RESTART, 8'($urandom_range(0, 255)));
        end
        msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 64)
                                              : $urandom_range(0, 20);
        for (int i = 0; i < msg_len; i++) begin
          send_item(OP_ABSORB, 8'($urandom_range(0, 255)));
        end
        send_item(OP_FINALIZE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 7) == 0) begin
          send_item(OP_FINALIZE, 8'($urandom_range(0, 255)));
        end
      end else begin
        send_item(op_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Watchdog: fail the run once the cycle count reaches the run limit.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("ghash_gf128_authenticator_tb failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_unused_cfg_index();
    // no idling, key all ones
    test_random_sessions(0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    // sender idle, key zero
    test_random_sessions(76, 0, 64'h0, 64'h0);
    // receiver stalling, key is the field's one element
    test_random_sessions(0, 76, 64'h8000_0000_0000_0000, 64'h0);
    // both idle, random key
    test_random_sessions(36, 36, {$urandom, $urandom}, {$urandom, $urandom});

    settle_block();
    error_count += pending_token_q.size();
    $display("covered %0d input transactions and %0d token halves", items_seen, halves_seen);
    $display("with %0d block multiplies under %0d key register writes", mult_count, key_writes);
    if (error_count == 0) begin
      $display("ghash_gf128_authenticator_tb passed");
    end else begin
      $display("ghash_gf128_authenticator_tb failed");
    end
    $finish;
  end

endmodule
